[hw/rtl/riscv_decode_stage_defines.svh]
// Assertion macros shared by the decode stage checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef RISCV_DECODE_STAGE_DEFINES_SVH
`define RISCV_DECODE_STAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RVD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decode stage check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define RVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decode stage check failed: next-cycle rule");

`endif

[hw/rtl/rvd_pkg.sv]
// Types and constants of the RV32I decode stage.
// Depends on nothing; imported by every module of the block.
package rvd_pkg;

  // Major opcode, bits 6..2 of the instruction word
  localparam logic [4:0] OPC_LOAD     = 5'h00;
  localparam logic [4:0] OPC_MISC_MEM = 5'h03;
  localparam logic [4:0] OPC_OP_IMM   = 5'h04;
  localparam logic [4:0] OPC_AUIPC    = 5'h05;
  localparam logic [4:0] OPC_STORE    = 5'h08;
  localparam logic [4:0] OPC_OP       = 5'h0C;
  localparam logic [4:0] OPC_LUI      = 5'h0D;
  localparam logic [4:0] OPC_BRANCH   = 5'h18;
  localparam logic [4:0] OPC_JALR     = 5'h19;
  localparam logic [4:0] OPC_JAL      = 5'h1B;
  localparam logic [4:0] OPC_SYSTEM   = 5'h1C;

  localparam logic [31:0] RET_WORD = 32'h0000_8067;

  // Configuration register indexes
  localparam logic CFG_CUSTOM_OPC = 1'b0;
  localparam logic CFG_EXIT_WORD  = 1'b1;

  localparam logic [4:0]  CUSTOM_OPC_RESET = 5'd2;
  localparam logic [31:0] EXIT_WORD_RESET  = 32'd0;

  localparam int NUM_FLAGS = 17;

  // Class flag bit positions
  localparam int FL_RS1USED = 0;
  localparam int FL_RS2USED = 1;
  localparam int FL_LOAD    = 2;
  localparam int FL_STORE   = 3;
  localparam int FL_CSTORE  = 4;
  localparam int FL_BRANCH  = 5;
  localparam int FL_JAL     = 6;
  localparam int FL_JALR    = 7;
  localparam int FL_RET     = 8;
  localparam int FL_EXIT    = 9;
  localparam int FL_LUI     = 10;
  localparam int FL_OPIMM   = 11;
  localparam int FL_SYSTEM  = 12;
  localparam int FL_JUMP    = 13;
  localparam int FL_CTRL    = 14;
  localparam int FL_NODEST  = 15;
  localparam int FL_RTYPE   = 16;

  typedef enum logic [3:0] {
    FMT_UNDEF = 4'd0,
    FMT_R     = 4'd1,
    FMT_I     = 4'd2,
    FMT_S     = 4'd3,
    FMT_CS    = 4'd4,
    FMT_B     = 4'd5,
    FMT_U     = 4'd6,
    FMT_J     = 4'd7,
    FMT_OTHER = 4'd8
  } fmt_t;

  typedef struct packed {
    logic [4:0]  custom_opc;
    logic [31:0] exit_word;
  } cfg_t;

  // Decoded fields of one item, all zero when nothing goes to issue
  typedef struct packed {
    logic                 issue_valid;
    logic                 next_fetch_valid;
    logic                 jal;
    fmt_t                 format_type;
    logic [4:0]           dest_reg;
    logic [4:0]           src1_reg;
    logic [4:0]           src2_reg;
    logic [2:0]           funct3_field;
    logic [6:0]           funct7_field;
    logic signed [31:0]   immediate;
    logic [NUM_FLAGS-1:0] class_flags;
  } dec_t;

endpackage

[hw/rtl/rvd_cfg.sv]
// Configuration registers: custom store opcode and exit word.
// Depends on rvd_pkg.
module rvd_cfg
  import rvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.custom_opc <= CUSTOM_OPC_RESET;
      cfg.exit_word  <= EXIT_WORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CUSTOM_OPC: cfg.custom_opc <= cfg_data[4:0];
        CFG_EXIT_WORD:  cfg.exit_word  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/rvd_hold.sv]
// Input stage: holding register for a stalled instruction and the stage register.
// Depends on rvd_pkg.
module rvd_hold
  import rvd_pkg::*;
#(
  parameter int PC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_valid,
  output logic               step_stall,
  input  logic               fetch_valid,
  input  logic [PC_BITS-1:0] fetch_pc,
  input  logic [31:0]        fetch_word,
  input  logic               issue_full,
  input  logic               drain,
  output logic               stage_valid,
  output logic               stage_go,
  output logic [PC_BITS-1:0] stage_pc,
  output logic [31:0]        stage_word
);

  logic               held_flag;
  logic [PC_BITS-1:0] held_pc;
  logic [31:0]        held_word;
  logic               accept;
  logic               take_new;
  logic               any_valid;

  assign step_stall = stage_valid && !drain;
  assign accept     = step_valid && !step_stall;
  assign take_new   = fetch_valid && !held_flag;
  assign any_valid  = fetch_valid || held_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag   <= 1'b0;
      stage_valid <= 1'b0;
    end else if (accept) begin
      held_flag   <= any_valid && issue_full;
      stage_valid <= 1'b1;
    end else if (drain) begin
      stage_valid <= 1'b0;
    end
  end

  // Payload: load a fresh fetch only when nothing is held
  always_ff @(posedge clk) begin
    if (accept) begin
      if (take_new) begin
        held_pc   <= fetch_pc;
        held_word <= fetch_word;
      end
      stage_go   <= any_valid && !issue_full;
      stage_pc   <= take_new ? fetch_pc : held_pc;
      stage_word <= take_new ? fetch_word : held_word;
    end
  end

endmodule

[hw/rtl/rvd_decoder.sv]
// Combinational RV32I decoder with configurable custom store and exit word.
// Depends on rvd_pkg.
module rvd_decoder
  import rvd_pkg::*;
(
  input  logic        go,
  input  logic [31:0] word,
  input  cfg_t        cfg,
  output dec_t        dec
);

  logic [4:0] opc;
  logic [4:0] rd;
  logic [4:0] rs1;
  logic [4:0] rs2;
  fmt_t       fmt;
  logic [31:0] imm;
  logic ld, st, cst, br, jal, jalr, lui, auipc, opimm, sys;
  logic u1, u2, nodest;
  logic [NUM_FLAGS-1:0] fl;

  assign opc = word[6:2];
  assign rd  = word[11:7];
  assign rs1 = word[19:15];
  assign rs2 = word[24:20];

  assign ld    = opc == OPC_LOAD;
  assign st    = opc == OPC_STORE;
  assign cst   = opc == cfg.custom_opc;
  assign br    = opc == OPC_BRANCH;
  assign jal   = opc == OPC_JAL;
  assign jalr  = opc == OPC_JALR;
  assign lui   = opc == OPC_LUI;
  assign auipc = opc == OPC_AUIPC;
  assign opimm = opc == OPC_OP_IMM;
  assign sys   = opc == OPC_SYSTEM;

  // Custom store wins over any standard opcode of the same value
  always_comb begin
    if (cst) begin
      fmt = FMT_CS;
    end else if (opc[2:0] == 3'b111) begin
      fmt = FMT_UNDEF;
    end else if (opc inside {OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM, OPC_JALR, OPC_SYSTEM}) begin
      fmt = FMT_I;
    end else if (opc inside {OPC_AUIPC, OPC_LUI}) begin
      fmt = FMT_U;
    end else begin
      case (opc)
        OPC_STORE:  fmt = FMT_S;
        OPC_OP:     fmt = FMT_R;
        OPC_BRANCH: fmt = FMT_B;
        OPC_JAL:    fmt = FMT_J;
        default:    fmt = FMT_OTHER;
      endcase
    end
  end

  // B and J offsets come out in half-words
  always_comb begin
    case (fmt)
      FMT_I:        imm = {{20{word[31]}}, word[31:20]};
      FMT_S, FMT_CS: imm = {{20{word[31]}}, word[31:25], word[11:7]};
      FMT_B:        imm = {{20{word[31]}}, word[31], word[7], word[30:25], word[11:8]};
      FMT_U:        imm = {word[31:12], 12'd0};
      FMT_J:        imm = {{12{word[31]}}, word[31], word[19:12], word[20], word[30:21]};
      default:      imm = 32'd0;
    endcase
  end

  assign u1     = !jal && !lui && !auipc && (rs1 != 5'd0);
  assign u2     = !opimm && !ld && !jal && !jalr && !lui && !auipc && (rs2 != 5'd0);
  assign nodest = br || st || cst || (rd == 5'd0);

  always_comb begin
    fl              = '0;
    fl[FL_RS1USED]  = u1;
    fl[FL_RS2USED]  = u2;
    fl[FL_LOAD]     = ld;
    fl[FL_STORE]    = st;
    fl[FL_CSTORE]   = cst;
    fl[FL_BRANCH]   = br;
    fl[FL_JAL]      = jal;
    fl[FL_JALR]     = jalr;
    fl[FL_RET]      = word == RET_WORD;
    fl[FL_EXIT]     = word == cfg.exit_word;
    fl[FL_LUI]      = lui;
    fl[FL_OPIMM]    = opimm;
    fl[FL_SYSTEM]   = sys;
    fl[FL_JUMP]     = jal || jalr;
    fl[FL_CTRL]     = br || jal || jalr;
    fl[FL_NODEST]   = nodest;
    fl[FL_RTYPE]    = fmt == FMT_R;
  end

  // Drop every field to zero when nothing goes to issue
  always_comb begin
    dec = '0;
    if (go) begin
      dec.issue_valid      = 1'b1;
      dec.next_fetch_valid = !(br || jalr);
      dec.jal              = jal;
      dec.format_type      = fmt;
      dec.dest_reg         = nodest ? 5'd0 : rd;
      dec.src1_reg         = rs1;
      dec.src2_reg         = rs2;
      dec.funct3_field     = word[14:12];
      dec.funct7_field     = word[31:25];
      dec.immediate        = imm;
      dec.class_flags      = fl;
    end
  end

endmodule

[hw/rtl/riscv_decode_stage.sv]
// RV32I decode stage with one holding register and an output register.
// Depends on rvd_pkg, rvd_cfg, rvd_hold and rvd_decoder.
//
// Use:
//   Input channel (step_valid / step_stall) moves one item per step: the
//   fetch offer (fetch_valid, fetch_pc, fetch_word) and the issue_full flag.
//   Every accepted item yields exactly one result item on the output channel
//   (result_valid / result_stall): the decoded instruction when one goes to
//   issue, otherwise an item with issue_valid low and all fields zero.
//   While issue_full is high the offered instruction is kept in the holding
//   register and decoded on a later step; new offers are ignored meanwhile.
//   From acceptance to result_valid an item passes one stage register, then
//   the decoder, then the output register. Throughput is one item per cycle
//   while the receiver does not stall; the stage register and the output register decouple the sides.
//   When the receiver stalls, the output register holds its item and the stage
//   register takes one more; step_stall is high while both are full and the
//   receiver stalls.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while no item is in flight.
//   Synchronous reset empties both registers, drops the held instruction and
//   restores the custom store opcode to 2 and the exit word to 0.
module riscv_decode_stage
  import rvd_pkg::*;
#(
  parameter int PC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  // input channel
  input  logic                 step_valid,
  output logic                 step_stall,
  input  logic                 fetch_valid,
  input  logic [PC_BITS-1:0]   fetch_pc,
  input  logic [31:0]          fetch_word,
  input  logic                 issue_full,
  // output channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 issue_valid,
  output logic                 next_fetch_valid,
  output logic [PC_BITS-1:0]   next_fetch_pc,
  output logic [PC_BITS-1:0]   issue_pc,
  output logic [3:0]           format_type,
  output logic [4:0]           dest_reg,
  output logic [4:0]           src1_reg,
  output logic [4:0]           src2_reg,
  output logic [2:0]           funct3_field,
  output logic [6:0]           funct7_field,
  output logic signed [31:0]   immediate,
  output logic [NUM_FLAGS-1:0] class_flags
);

  cfg_t               cfg;
  logic               out_ready;
  logic               stage_valid;
  logic               stage_go;
  logic [PC_BITS-1:0] stage_pc;
  logic [31:0]        stage_word;
  dec_t               dec;
  logic [31:0]        imm_x2;
  logic [PC_BITS-1:0] pc_step;
  logic [PC_BITS-1:0] nfpc;

  // The output register takes a new item whenever it is empty or being read
  assign out_ready = !result_valid || !result_stall;

  rvd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rvd_hold #(
    .PC_BITS (PC_BITS)
  ) u_hold (
    .clk         (clk),
    .rst         (rst),
    .step_valid  (step_valid),
    .step_stall  (step_stall),
    .fetch_valid (fetch_valid),
    .fetch_pc    (fetch_pc),
    .fetch_word  (fetch_word),
    .issue_full  (issue_full),
    .drain       (out_ready),
    .stage_valid (stage_valid),
    .stage_go    (stage_go),
    .stage_pc    (stage_pc),
    .stage_word  (stage_word)
  );

  rvd_decoder u_dec (
    .go   (stage_go),
    .word (stage_word),
    .cfg  (cfg),
    .dec  (dec)
  );

  // Next fetch pc: JAL jumps by twice the half-word offset, else advance by 4.
  // Wrap at PC_BITS.
  assign imm_x2  = {dec.immediate[30:0], 1'b0};
  assign pc_step = dec.jal ? imm_x2[PC_BITS-1:0] : PC_BITS'(4);
  assign nfpc    = stage_pc + pc_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= stage_valid;
    end
  end

  // Hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (out_ready && stage_valid) begin
      issue_valid      <= dec.issue_valid;
      next_fetch_valid <= dec.next_fetch_valid;
      next_fetch_pc    <= dec.issue_valid ? nfpc : '0;
      issue_pc         <= dec.issue_valid ? stage_pc : '0;
      format_type      <= dec.format_type;
      dest_reg         <= dec.dest_reg;
      src1_reg         <= dec.src1_reg;
      src2_reg         <= dec.src2_reg;
      funct3_field     <= dec.funct3_field;
      funct7_field     <= dec.funct7_field;
      immediate        <= dec.immediate;
      class_flags      <= dec.class_flags;
    end
  end

endmodule

[hw/rtl/rvd_checker.sv]
// Port-level checker for the decode stage, bound to its top level.
// Depends on rvd_pkg and riscv_decode_stage_defines.svh.
`include "riscv_decode_stage_defines.svh"

module rvd_checker
  import rvd_pkg::*;
#(
  parameter int PC_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_stall,
  input logic                 issue_valid,
  input logic                 next_fetch_valid,
  input logic [PC_BITS-1:0]   next_fetch_pc,
  input logic [PC_BITS-1:0]   issue_pc,
  input logic [4:0]           dest_reg,
  input logic signed [31:0]   immediate,
  input logic [NUM_FLAGS-1:0] class_flags
);

  // A stalled result keeps its pc and flags
  `RVD_ASSERT_NEXT(a_stall_hold, clk, rst, result_valid && result_stall, result_valid && $stable(issue_pc) && $stable(class_flags))

  // An item with nothing for issue carries only zeros
  `RVD_ASSERT_IMPLY(a_empty_zero, clk, rst, result_valid && !issue_valid, !next_fetch_valid && immediate == 32'sd0 && class_flags == '0 && issue_pc == '0 && next_fetch_pc == '0)

  // A destination register is never reported with the no-destination flag
  `RVD_ASSERT_IMPLY(a_dest_flag, clk, rst, result_valid && dest_reg != 5'd0, !class_flags[FL_NODEST])

  // Branches and JALR withhold the next fetch pc
  `RVD_ASSERT_IMPLY(a_ctrl_nfpc, clk, rst, result_valid && (class_flags[FL_BRANCH] || class_flags[FL_JALR]), !next_fetch_valid)

  // A return is a JALR jump
  `RVD_ASSERT_IMPLY(a_ret_jalr, clk, rst, result_valid && class_flags[FL_RET], class_flags[FL_JALR] && class_flags[FL_JUMP])

endmodule

bind riscv_decode_stage rvd_checker #(.PC_BITS(PC_BITS)) u_rvd_checker (.*);
